>>> hw/rtl/rxaf_pkg.sv
// Shared types and constants for the receive address filter.
// No dependencies; every other file of the block but rxaf_out_if imports this package.
package rxaf_pkg;

    localparam int ADDR_W     = 48;
    localparam int MODE_W     = 5;
    localparam int CNT_W      = 6;
    localparam int SLOT_W     = 5;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Command codes.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Frame classes.
    localparam logic [CLASS_W-1:0] CLASS_DIRECTED  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MULTICAST = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BROADCAST = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_OTHER     = 2'd3;

    // Bit positions inside filter_mode.
    localparam int MODE_DIRECTED  = 0;
    localparam int MODE_MCLIST    = 1;
    localparam int MODE_ALLMCAST  = 2;
    localparam int MODE_BROADCAST = 3;
    localparam int MODE_PROMISC   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MCAST_COUNT     = 2'd2;

    // What one cell hands to its right neighbor every cycle.
    typedef struct packed {
        logic              tok;
        logic              hit;
        logic [ADDR_W-1:0] key;
    } t_link;

endpackage

>>> hw/rtl/rxaf_in_if.sv
// Request channel of the receive address filter: check and table write words.
// Depends on rxaf_pkg for field widths.
interface rxaf_in_if import rxaf_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [ADDR_W-1:0]      dest_address;
    logic [CLASS_W-1:0]     frame_type;
    logic [SLOT_W-1:0]      entry_index;
    logic [ADDR_W-1:0]      entry_address;

    modport source (output valid, cmd, dest_address, frame_type, entry_index,
                    entry_address, input ready);
    modport sink   (input valid, cmd, dest_address, frame_type, entry_index,
                    entry_address, output ready);
endinterface

>>> hw/rtl/rxaf_out_if.sv
// Result channel of the receive address filter: one accept bit per check.
// No dependencies.
interface rxaf_out_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, accepted, input ready);
    modport sink   (input valid, accepted, output ready);
endinterface

>>> hw/rtl/mac_receive_address_filter.sv
// Channel   Dir  Handshake      Word
// i_req     in   valid/ready    cmd, dest_address, frame_type, entry_index, entry_address
// o_rsp     out  valid/ready    accepted (one per check, none per table write)
// i_cfg_*   in   write enable   register index, 48-bit data
//
// A check that does not consult the multicast list shows its result the cycle
// after it is accepted; a list lookup walks the chain of MCAST_ENTRIES cell
// registers and then the result register, one lookup at a time. A new word is
// taken once the chain is empty and the result register is empty or being read.
// Reset is synchronous; table contents are not cleared and must be written
// before use.
// Top level of the receive address filter; depends on rxaf_pkg, the two
// channel interfaces and rxaf_cell.
module mac_receive_address_filter import rxaf_pkg::*; #(
    parameter int MCAST_ENTRIES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rxaf_in_if.sink               i_req,
    rxaf_out_if.source            o_rsp
);

    logic [MODE_W-1:0] r_filter_mode;
    logic [ADDR_W-1:0] r_station_address;
    logic [CNT_W-1:0]  r_mcast_count;
    logic              r_busy;
    logic              r_out_valid;
    logic              r_accepted;

    logic  w_acc;
    logic  w_check;
    logic  w_lookup;
    logic  w_direct;
    t_link w_link [0:MCAST_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode     <= '0;
            r_station_address <= '0;
            r_mcast_count     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FILTER_MODE:     r_filter_mode     <= i_cfg_data[MODE_W-1:0];
                REG_STATION_ADDRESS: r_station_address <= i_cfg_data[ADDR_W-1:0];
                REG_MCAST_COUNT:     r_mcast_count     <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = !r_busy && (!r_out_valid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_check     = w_acc && (i_req.cmd == CMD_CHECK);

    // Only a multicast frame under the list enable, with neither promiscuous
    // nor all-multicast set, needs the table.
    assign w_lookup = (i_req.frame_type == CLASS_MULTICAST)
                   && r_filter_mode[MODE_MCLIST]
                   && !r_filter_mode[MODE_ALLMCAST]
                   && !r_filter_mode[MODE_PROMISC];

    always_comb begin
        w_direct = 1'b0;
        if (r_filter_mode[MODE_PROMISC]) begin
            w_direct = 1'b1;
        end else begin
            unique case (i_req.frame_type)
                CLASS_BROADCAST: w_direct = r_filter_mode[MODE_BROADCAST];
                CLASS_MULTICAST: w_direct = r_filter_mode[MODE_ALLMCAST];
                CLASS_DIRECTED:  w_direct = r_filter_mode[MODE_DIRECTED]
                                         && (i_req.dest_address == r_station_address);
                CLASS_OTHER:     w_direct = 1'b0;
                default:         w_direct = 1'b0;
            endcase
        end
    end

    assign w_link[0].tok = w_check && w_lookup;
    assign w_link[0].hit = 1'b0;
    assign w_link[0].key = i_req.dest_address;

    genvar g;
    generate
        for (g = 0; g < MCAST_ENTRIES; g++) begin : g_cell
            logic w_wr_en;
            logic w_en;

            assign w_wr_en = w_acc && (i_req.cmd == CMD_WRITE)
                          && (int'(i_req.entry_index) == g);
            assign w_en    = (g < int'(r_mcast_count));

            rxaf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_wr_en   (w_wr_en),
                .i_wr_addr (i_req.entry_address),
                .i_en      (w_en),
                .i_link    (w_link[g]),
                .o_link    (w_link[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_check && w_lookup) begin
                r_busy <= 1'b1;
            end else if (w_link[MCAST_ENTRIES].tok) begin
                r_busy <= 1'b0;
            end

            // The result register is always free when a lookup leaves the chain.
            if ((w_check && !w_lookup) || w_link[MCAST_ENTRIES].tok) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_check && !w_lookup) begin
            r_accepted <= w_direct;
        end else if (w_link[MCAST_ENTRIES].tok) begin
            r_accepted <= w_link[MCAST_ENTRIES].hit;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.accepted = r_accepted;

endmodule

>>> hw/rtl/rxaf_cell.sv
// One multicast table slot with its comparator, one link of the lookup chain.
// Depends on rxaf_pkg.
module rxaf_cell import rxaf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic              i_en,
    input  t_link             i_link,
    output t_link             o_link
);

    logic [ADDR_W-1:0] r_entry;
    t_link             r_link;
    t_link             n_link;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_addr;
        end
    end

    // A slot at or beyond the programmed count never reports a hit.
    always_comb begin
        n_link     = i_link;
        n_link.hit = i_link.hit | (i_link.tok & i_en & (r_entry == i_link.key));
    end

    // The key travels without reset; only the token and the hit flag are cleared.
    always_ff @(posedge i_clk) begin
        r_link.key <= n_link.key;
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
            r_link.hit <= 1'b0;
        end else begin
            r_link.tok <= n_link.tok;
            r_link.hit <= n_link.hit;
        end
    end

    assign o_link = r_link;

endmodule

>>> hw/rtl/rxaf_checker.sv
// Port-level checks for the receive address filter, bound to its top level.
// Depends on rxaf_pkg and mac_receive_address_filter.
module rxaf_checker import rxaf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_req_cmd,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input logic o_rsp_accepted
);

    // A stalled result word holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp_accepted)))
        else $error("result word changed while stalled");

    // No result is shown right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    // A waiting result that is not taken blocks new words.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |-> !i_req_ready)
        else $error("request taken while result stalled");

    // A table write never produces a result word.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_cmd == CMD_WRITE) && !o_rsp_valid)
        |=> !o_rsp_valid)
        else $error("table write produced a result");

endmodule

bind mac_receive_address_filter rxaf_checker u_rxaf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_cmd      (i_req.cmd),
    .o_rsp_valid    (o_rsp.valid),
    .o_rsp_ready    (o_rsp.ready),
    .o_rsp_accepted (o_rsp.accepted)
);
